>>> src/srg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srg_pkg
// Shared constants, codes and control bundles for the sparse row gather block.
// ----------------------------------------------------------------------------
package srg_pkg;

    // default sizes
    localparam int ENTRIES_DEF = 64;
    localparam int ROWS_DEF    = 256;

    // row coordinates are 8 bits wide, so no more than 256 rows are addressable
    localparam int ROW_LIMIT   = 256;

    // fixed field widths
    localparam int CMD_W   = 2;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 32;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 16;
    localparam int RCNT_W  = 9;
    localparam int STAT_W  = 3;
    localparam int ENTRY_W = COL_W + VAL_W;

    localparam logic [RCNT_W-1:0] ROW_COUNT_RST = 9'd256;
    localparam logic [POS_W-1:0]  POS_MAX       = 16'hFFFF;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GATHER = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANGE     = 3'd1;
    localparam logic [STAT_W-1:0] ST_ORDER     = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_SATURATED = 3'd4;

    // row directory strobes
    typedef struct packed {
        logic clear;
        logic wr_en;
        logic rd_en;
    } dir_ctl_t;

    // entry store strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage : srg_pkg
`default_nettype wire

>>> src/srg_row_dir.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srg_row_dir
// Row directory: run start and length per row in a synchronous memory, plus a
// seen flag per row in flip-flops that a clear wipes all together.
// ----------------------------------------------------------------------------
module srg_row_dir #(
    parameter int ENTRIES = srg_pkg::ENTRIES_DEF,
    parameter int ROWS    = srg_pkg::ROWS_DEF
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  srg_pkg::dir_ctl_t                     ctl,
    input  wire [$clog2((ROWS < srg_pkg::ROW_LIMIT) ? ROWS : srg_pkg::ROW_LIMIT)-1:0] wr_row,
    input  wire [$clog2(ENTRIES)-1:0]             wr_start,
    input  wire [$clog2(ENTRIES+1)-1:0]           wr_size,
    input  wire [$clog2((ROWS < srg_pkg::ROW_LIMIT) ? ROWS : srg_pkg::ROW_LIMIT)-1:0] rd_row,
    output logic [$clog2(ENTRIES)-1:0]            rd_start,
    output logic [$clog2(ENTRIES+1)-1:0]          rd_size,
    output logic                                  rd_seen
);

    localparam int ROW_DEPTH = (ROWS < srg_pkg::ROW_LIMIT) ? ROWS : srg_pkg::ROW_LIMIT;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES+1);

    logic [IDX_W+CNT_W-1:0] dir_mem [ROW_DEPTH];
    logic [ROW_DEPTH-1:0]   seen_reg;
    logic [IDX_W+CNT_W-1:0] rd_data_reg;
    logic                   rd_seen_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            dir_mem[wr_row] <= {wr_start, wr_size};
        end
        if (ctl.rd_en) begin
            rd_data_reg <= dir_mem[rd_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            seen_reg <= '0;
        end else if (ctl.wr_en) begin
            seen_reg[wr_row] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_seen_reg <= 1'b0;
        end else if (ctl.rd_en) begin
            rd_seen_reg <= seen_reg[rd_row];
        end
    end

    assign rd_start = rd_data_reg[IDX_W+CNT_W-1:CNT_W];
    assign rd_size  = rd_data_reg[CNT_W-1:0];
    assign rd_seen  = rd_seen_reg;

endmodule : srg_row_dir
`default_nettype wire

>>> src/srg_entry_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srg_entry_mem
// Entry store: one write and one registered read port, {value, column}.
// ----------------------------------------------------------------------------
module srg_entry_mem #(
    parameter int ENTRIES = srg_pkg::ENTRIES_DEF
) (
    input  wire                              aclk,
    input  srg_pkg::mem_ctl_t                ctl,
    input  wire  [$clog2(ENTRIES)-1:0]       wr_addr,
    input  wire  [srg_pkg::ENTRY_W-1:0]      wr_data,
    input  wire  [$clog2(ENTRIES)-1:0]       rd_addr,
    output logic [srg_pkg::ENTRY_W-1:0]      rd_data
);

    logic [srg_pkg::ENTRY_W-1:0] mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : srg_entry_mem
`default_nettype wire

>>> src/sparse_row_gather.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_row_gather
// Gathers whole rows of a coordinate-format sparse matrix. Entries are loaded
// in row order after a clear; a gather request streams out that row's entries
// renumbered to the request's position since the clear.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Carries
//  s_*      in   s_valid / s_ready    command, load entry, gather row
//  m_*      out  m_valid / m_ready    position, column, value, found, last, status
//  cfg_*    in   cfg_wr_en            row_count, no back-pressure
//
//  Clear, load, spare commands and gather errors are taken in the idle state;
//  clear, load and gather error results go to the output register in the same
//  cycle, spare gives none. Gather: directory read on acceptance, first entry
//  store read in S_LOOKUP, then one entry a cycle in S_PUSH while m_ready stays
//  high; an empty row ends in S_LOOKUP. No new item is taken until it is done.
//  Reset is synchronous; the seen flags are cleared at once, no sweep needed.
//  A stall on m_ready holds the output register and the pending store read;
//  input is only taken when the output register is free or draining.
// ----------------------------------------------------------------------------
module sparse_row_gather #(
    parameter int ENTRIES = srg_pkg::ENTRIES_DEF,
    parameter int ROWS    = srg_pkg::ROWS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,

    input  wire                              cfg_wr_en,
    input  wire  [srg_pkg::RCNT_W-1:0]       cfg_wr_data,

    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [srg_pkg::CMD_W-1:0]        s_cmd,
    input  wire  [srg_pkg::ROW_W-1:0]        s_entry_row,
    input  wire  [srg_pkg::COL_W-1:0]        s_entry_col,
    input  wire  [srg_pkg::VAL_W-1:0]        s_entry_value,
    input  wire  [srg_pkg::ROW_W-1:0]        s_gather_row,

    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [srg_pkg::POS_W-1:0]        m_out_row,
    output logic [srg_pkg::COL_W-1:0]        m_out_col,
    output logic [srg_pkg::VAL_W-1:0]        m_out_value,
    output logic                             m_found,
    output logic                             m_last,
    output logic [srg_pkg::STAT_W-1:0]       m_status
);

    localparam int ROW_DEPTH = (ROWS < srg_pkg::ROW_LIMIT) ? ROWS : srg_pkg::ROW_LIMIT;
    localparam int RIDX_W    = $clog2(ROW_DEPTH);
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES+1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_PUSH
    } state_t;

    // control state
    state_t                        state_reg,       state_next;
    logic [srg_pkg::RCNT_W-1:0]    row_count_reg;
    logic [CNT_W-1:0]              entry_count_reg, entry_count_next;
    logic [srg_pkg::ROW_W-1:0]     last_row_reg,    last_row_next;
    logic                          last_vld_reg,    last_vld_next;   // low: no row loaded yet
    logic [IDX_W-1:0]              run_start_reg,   run_start_next;
    logic [CNT_W-1:0]              run_size_reg,    run_size_next;
    logic [srg_pkg::POS_W-1:0]     pos_reg,         pos_next;
    logic [srg_pkg::POS_W-1:0]     gpos_reg,        gpos_next;      // position of current gather
    logic [IDX_W-1:0]              rd_idx_reg,      rd_idx_next;
    logic [CNT_W-1:0]              rem_reg,         rem_next;       // results still to push

    // output register
    logic                          m_valid_reg,     m_valid_next;
    logic [srg_pkg::POS_W-1:0]     m_row_reg,       m_row_next;
    logic [srg_pkg::COL_W-1:0]     m_col_reg,       m_col_next;
    logic [srg_pkg::VAL_W-1:0]     m_val_reg,       m_val_next;
    logic                          m_found_reg,     m_found_next;
    logic                          m_last_reg,      m_last_next;
    logic [srg_pkg::STAT_W-1:0]    m_stat_reg,      m_stat_next;

    // memory side
    srg_pkg::dir_ctl_t             dir_ctl;
    logic [RIDX_W-1:0]             dir_wr_row;
    logic [IDX_W-1:0]              dir_wr_start;
    logic [CNT_W-1:0]              dir_wr_size;
    logic [RIDX_W-1:0]             dir_rd_row;
    logic [IDX_W-1:0]              dir_start;
    logic [CNT_W-1:0]              dir_size;
    logic                          dir_seen;

    srg_pkg::mem_ctl_t             mem_ctl;
    logic [IDX_W-1:0]              mem_rd_addr;
    logic [srg_pkg::ENTRY_W-1:0]   mem_rd_data;

    logic                          slot_free;
    logic                          in_acc;
    logic                          load_in_range;
    logic                          gather_in_range;
    logic                          load_order_bad;
    logic                          store_full;
    logic                          new_run;
    logic                          row_empty;

    srg_row_dir #(
        .ENTRIES (ENTRIES),
        .ROWS    (ROWS)
    ) u_row_dir (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (dir_ctl),
        .wr_row   (dir_wr_row),
        .wr_start (dir_wr_start),
        .wr_size  (dir_wr_size),
        .rd_row   (dir_rd_row),
        .rd_start (dir_start),
        .rd_size  (dir_size),
        .rd_seen  (dir_seen)
    );

    srg_entry_mem #(
        .ENTRIES (ENTRIES)
    ) u_entry_mem (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .wr_addr (entry_count_reg[IDX_W-1:0]),
        .wr_data ({s_entry_value, s_entry_col}),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output slot may be reloaded when empty or being taken this cycle
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && slot_free;
    assign in_acc    = s_valid && s_ready;

    // range: below row_count and inside the directory
    assign load_in_range   = ({1'b0, s_entry_row}  < row_count_reg) &&
                             ({1'b0, s_entry_row}  < srg_pkg::RCNT_W'(ROW_DEPTH));
    assign gather_in_range = ({1'b0, s_gather_row} < row_count_reg) &&
                             ({1'b0, s_gather_row} < srg_pkg::RCNT_W'(ROW_DEPTH));
    assign load_order_bad  = last_vld_reg && (s_entry_row < last_row_reg);
    assign store_full      = (entry_count_reg == CNT_W'(ENTRIES));
    assign new_run         = !last_vld_reg || (s_entry_row != last_row_reg);
    assign row_empty       = !dir_seen || (dir_size == '0);

    assign dir_wr_row   = s_entry_row[RIDX_W-1:0];
    assign dir_rd_row   = s_gather_row[RIDX_W-1:0];
    assign dir_wr_start = run_start_next;
    assign dir_wr_size  = run_size_next;

    always_comb begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        last_row_next    = last_row_reg;
        last_vld_next    = last_vld_reg;
        run_start_next   = run_start_reg;
        run_size_next    = run_size_reg;
        pos_next         = pos_reg;
        gpos_next        = gpos_reg;
        rd_idx_next      = rd_idx_reg;
        rem_next         = rem_reg;

        m_valid_next = m_valid_reg && !m_ready;
        m_row_next   = m_row_reg;
        m_col_next   = m_col_reg;
        m_val_next   = m_val_reg;
        m_found_next = m_found_reg;
        m_last_next  = m_last_reg;
        m_stat_next  = m_stat_reg;

        dir_ctl     = '0;
        mem_ctl     = '0;
        mem_rd_addr = rd_idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    // default single acknowledgement
                    m_row_next   = '0;
                    m_col_next   = '0;
                    m_val_next   = '0;
                    m_found_next = 1'b0;
                    m_last_next  = 1'b1;
                    m_stat_next  = srg_pkg::ST_OK;
                    unique case (s_cmd)
                        srg_pkg::CMD_CLEAR: begin
                            m_valid_next     = 1'b1;
                            dir_ctl.clear    = 1'b1;
                            entry_count_next = '0;
                            last_vld_next    = 1'b0;
                            pos_next         = '0;
                        end
                        srg_pkg::CMD_LOAD: begin
                            m_valid_next = 1'b1;
                            priority if (!load_in_range) begin
                                m_stat_next = srg_pkg::ST_RANGE;
                            end else if (load_order_bad) begin
                                m_stat_next = srg_pkg::ST_ORDER;
                            end else if (store_full) begin
                                m_stat_next = srg_pkg::ST_FULL;
                            end else begin
                                // running run length is written through every load
                                if (new_run) begin
                                    run_start_next = entry_count_reg[IDX_W-1:0];
                                    run_size_next  = CNT_W'(1);
                                end else begin
                                    run_size_next  = run_size_reg + CNT_W'(1);
                                end
                                last_row_next    = s_entry_row;
                                last_vld_next    = 1'b1;
                                dir_ctl.wr_en    = 1'b1;
                                mem_ctl.wr_en    = 1'b1;
                                entry_count_next = entry_count_reg + CNT_W'(1);
                            end
                        end
                        srg_pkg::CMD_GATHER: begin
                            priority if (!gather_in_range) begin
                                m_valid_next = 1'b1;
                                m_stat_next  = srg_pkg::ST_RANGE;
                            end else if (pos_reg == srg_pkg::POS_MAX) begin
                                m_valid_next = 1'b1;
                                m_stat_next  = srg_pkg::ST_SATURATED;
                            end else begin
                                dir_ctl.rd_en = 1'b1;
                                gpos_next     = pos_reg;
                                pos_next      = pos_reg + srg_pkg::POS_W'(1);
                                state_next    = S_LOOKUP;
                            end
                        end
                        srg_pkg::CMD_SPARE: begin
                            // taken and dropped, no result
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_LOOKUP: begin
                if (row_empty) begin
                    if (slot_free) begin
                        m_valid_next = 1'b1;
                        m_row_next   = gpos_reg;
                        m_col_next   = '0;
                        m_val_next   = '0;
                        m_found_next = 1'b0;
                        m_last_next  = 1'b1;
                        m_stat_next  = srg_pkg::ST_OK;
                        state_next   = S_IDLE;
                    end
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    mem_rd_addr   = dir_start;
                    rd_idx_next   = dir_start + IDX_W'(1);
                    rem_next      = dir_size;
                    state_next    = S_PUSH;
                end
            end

            S_PUSH: begin
                // read data holds until pushed: the store is only read on issue
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_row_next   = gpos_reg;
                    m_col_next   = mem_rd_data[srg_pkg::COL_W-1:0];
                    m_val_next   = mem_rd_data[srg_pkg::ENTRY_W-1:srg_pkg::COL_W];
                    m_found_next = 1'b1;
                    m_last_next  = (rem_reg == CNT_W'(1));
                    m_stat_next  = srg_pkg::ST_OK;
                    rem_next     = rem_reg - CNT_W'(1);
                    if (rem_reg == CNT_W'(1)) begin
                        state_next = S_IDLE;
                    end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_idx_next   = rd_idx_reg + IDX_W'(1);
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            row_count_reg   <= srg_pkg::ROW_COUNT_RST;
            entry_count_reg <= '0;
            last_vld_reg    <= 1'b0;
            pos_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            if (cfg_wr_en) begin
                row_count_reg <= cfg_wr_data;
            end
            entry_count_reg <= entry_count_next;
            last_vld_reg    <= last_vld_next;
            pos_reg         <= pos_next;
            m_valid_reg     <= m_valid_next;
        end
        last_row_reg  <= last_row_next;
        run_start_reg <= run_start_next;
        run_size_reg  <= run_size_next;
        gpos_reg      <= gpos_next;
        rd_idx_reg    <= rd_idx_next;
        rem_reg       <= rem_next;
        m_row_reg     <= m_row_next;
        m_col_reg     <= m_col_next;
        m_val_reg     <= m_val_next;
        m_found_reg   <= m_found_next;
        m_last_reg    <= m_last_next;
        m_stat_reg    <= m_stat_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_row   = m_row_reg;
    assign m_out_col   = m_col_reg;
    assign m_out_value = m_val_reg;
    assign m_found     = m_found_reg;
    assign m_last      = m_last_reg;
    assign m_status    = m_stat_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_push_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PUSH) |-> (rem_reg != '0))
        else $error("streaming with no entries left");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond store depth");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_found_reg) |-> (m_stat_reg == srg_pkg::ST_OK))
        else $error("entry emitted with error status");

    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && (s_cmd == srg_pkg::CMD_GATHER) && gather_in_range &&
         (pos_reg != srg_pkg::POS_MAX))
        |=> (pos_reg == $past(pos_reg) + srg_pkg::POS_W'(1)) && (state_reg == S_LOOKUP))
        else $error("gather position not advanced");

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("input taken during a gather");

endmodule : sparse_row_gather
`default_nettype wire
